>>> rtl/kic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kic_pkg
// Shared types, key codes and helpers for the keystroke integer calculator.
// ----------------------------------------------------------------------------
package kic_pkg;

   localparam int DATA_W = 32;
   localparam int KEY_W  = 8;
   localparam int CNT_W  = $clog2(DATA_W);
   localparam int DIG_W  = 4;

   localparam logic [CNT_W-1:0]  ITER_LAST = CNT_W'(DATA_W - 1);
   localparam logic [DATA_W-1:0] TEN       = DATA_W'(10);

   // key codes
   localparam logic [KEY_W-1:0] KEY_ZERO   = 8'd48;
   localparam logic [KEY_W-1:0] KEY_NINE   = 8'd57;
   localparam logic [KEY_W-1:0] KEY_PLUS   = 8'd43;
   localparam logic [KEY_W-1:0] KEY_MINUS  = 8'd45;
   localparam logic [KEY_W-1:0] KEY_STAR   = 8'd42;
   localparam logic [KEY_W-1:0] KEY_SLASH  = 8'd47;
   localparam logic [KEY_W-1:0] KEY_PCT    = 8'd37;
   localparam logic [KEY_W-1:0] KEY_CARET  = 8'd94;
   localparam logic [KEY_W-1:0] KEY_BAR    = 8'd124;
   localparam logic [KEY_W-1:0] KEY_AMP    = 8'd38;
   localparam logic [KEY_W-1:0] KEY_EQUALS = 8'd61;

   // calculator operator, in key order + - * / % ^ | &
   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_XOR, OP_OR, OP_AND
   } calc_op_type;

   // operations of the shared arithmetic engine
   typedef enum logic [3:0] {
      ENG_ACC, ENG_ADD, ENG_SUB, ENG_MUL, ENG_DIV, ENG_REM, ENG_XOR, ENG_OR, ENG_AND
   } eng_op_type;

   typedef enum logic [1:0] {
      S_IDLE, S_BUSY, S_LOAD
   } ctl_state_type;

   typedef enum logic [1:0] {
      E_IDLE, E_ITER, E_FIN
   } eng_state_type;

   typedef struct packed {
      logic             start;
      eng_op_type       op;
      logic [DIG_W-1:0] digit;
   } eng_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } eng_stat_type;

   typedef struct packed {
      logic        hit;
      calc_op_type code;
   } op_lookup_type;

   function automatic logic is_positive(input logic [DATA_W-1:0] v);
      return (v != '0) && !v[DATA_W-1];
   endfunction

   function automatic logic is_digit(input logic [KEY_W-1:0] k);
      return (k >= KEY_ZERO) && (k <= KEY_NINE);
   endfunction

   function automatic op_lookup_type op_lookup(input logic [KEY_W-1:0] k);
      op_lookup_type r;
      r.hit  = 1'b1;
      r.code = OP_ADD;
      case (k)
         KEY_PLUS:  r.code = OP_ADD;
         KEY_MINUS: r.code = OP_SUB;
         KEY_STAR:  r.code = OP_MUL;
         KEY_SLASH: r.code = OP_DIV;
         KEY_PCT:   r.code = OP_REM;
         KEY_CARET: r.code = OP_XOR;
         KEY_BAR:   r.code = OP_OR;
         KEY_AMP:   r.code = OP_AND;
         default:   r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   function automatic eng_op_type calc_to_eng(input calc_op_type c);
      eng_op_type e;
      case (c)
         OP_ADD:  e = ENG_ADD;
         OP_SUB:  e = ENG_SUB;
         OP_MUL:  e = ENG_MUL;
         OP_DIV:  e = ENG_DIV;
         OP_REM:  e = ENG_REM;
         OP_XOR:  e = ENG_XOR;
         OP_OR:   e = ENG_OR;
         default: e = ENG_AND;
      endcase
      return e;
   endfunction

endpackage
`default_nettype wire

>>> rtl/kic_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kic_engine
// Iterative arithmetic engine: one 33-bit adder shared by shift-add multiply,
// restoring divide, digit accumulation and the final add or subtract.
// ----------------------------------------------------------------------------
module kic_engine
   import kic_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire eng_cmd_type       cmd,
   input  wire logic [DATA_W-1:0] opa,
   input  wire logic [DATA_W-1:0] opb,
   output eng_stat_type           stat,
   output logic [DATA_W-1:0]      result
);

   eng_state_type     state_ff, state_in;
   eng_op_type        op_ff, op_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DIG_W-1:0]  dig_ff, dig_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] res_ff, res_in;

   logic              div_op;
   logic [DATA_W-1:0] rs;
   logic [DATA_W-1:0] add_x, add_y;
   logic              add_cin;
   logic [DATA_W:0]   sum;

   assign div_op = (op_ff == ENG_DIV) || (op_ff == ENG_REM);
   assign rs     = {acc_ff[DATA_W-2:0], quo_ff[DATA_W-1]};

   // shared adder
   assign sum = {1'b0, add_x} + {1'b0, add_y} + {{DATA_W{1'b0}}, add_cin};

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      dig_ff <= dig_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   // sequence the shared adder
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      dig_in   = dig_ff;
      acc_in   = acc_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      add_x    = acc_ff;
      add_y    = '0;
      add_cin  = 1'b0;
      stat     = '0;

      case (state_ff)
         E_IDLE: begin
            if (cmd.start) begin
               op_in  = cmd.op;
               a_in   = opa;
               b_in   = opb;
               dig_in = cmd.digit;
               acc_in = '0;
               cnt_in = '0;
               // multiplier bits or dividend bits shift out of quo
               if ((cmd.op == ENG_DIV) || (cmd.op == ENG_REM)) begin
                  quo_in = opa;
               end else begin
                  quo_in = opb;
               end
               if ((cmd.op == ENG_ACC) || (cmd.op == ENG_MUL) ||
                   (cmd.op == ENG_DIV) || (cmd.op == ENG_REM)) begin
                  state_in = E_ITER;
               end else begin
                  state_in = E_FIN;
               end
            end
         end
         E_ITER: begin
            stat.busy = 1'b1;
            if (div_op) begin
               // trial subtract of the divisor from the shifted remainder
               add_x   = rs;
               add_y   = ~b_ff;
               add_cin = 1'b1;
               acc_in  = sum[DATA_W] ? sum[DATA_W-1:0] : rs;
               quo_in  = {quo_ff[DATA_W-2:0], sum[DATA_W]};
            end else begin
               // shift partial product, add multiplicand on a set bit
               add_x  = {acc_ff[DATA_W-2:0], 1'b0};
               add_y  = quo_ff[DATA_W-1] ? a_ff : '0;
               acc_in = sum[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ITER_LAST) begin
               state_in = E_FIN;
            end
         end
         E_FIN: begin
            stat.busy = 1'b1;
            stat.done = 1'b1;
            case (op_ff)
               ENG_ADD: begin
                  add_x = a_ff;
                  add_y = b_ff;
               end
               ENG_SUB: begin
                  add_x   = a_ff;
                  add_y   = ~b_ff;
                  add_cin = 1'b1;
               end
               ENG_ACC: begin
                  add_x = acc_ff;
                  add_y = {{(DATA_W-DIG_W){1'b0}}, dig_ff};
               end
               default: begin
                  add_x = acc_ff;
                  add_y = '0;
               end
            endcase
            case (op_ff)
               ENG_DIV: res_in = quo_ff;
               ENG_REM: res_in = acc_ff;
               ENG_XOR: res_in = a_ff ^ b_ff;
               ENG_OR:  res_in = a_ff | b_ff;
               ENG_AND: res_in = a_ff & b_ff;
               default: res_in = sum[DATA_W-1:0];
            endcase
            state_in = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   assign result = res_ff;

endmodule
`default_nettype wire

>>> rtl/keystroke_integer_calculator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keystroke_integer_calculator_top
// Keystroke calculator: builds two decimal operands from ASCII keys, applies
// one of + - * / % ^ | & on '=', and returns one response beat per key.
// ----------------------------------------------------------------------------
// One key beat in, one response beat out. A digit or an accepted '=' runs on the
// shared engine: 32 steps of the 33-bit adder (shift-add multiply by ten for
// digits, shift-add multiply or restoring divide for the operator), a finish
// step and a write-back step into the output register; add, subtract and the
// bitwise operators skip the 32 steps. Any other key is answered in the cycle
// after accept. req_tready stays low while a key is in work or its response
// beat still sits in the output register.
module keystroke_integer_calculator_top
   import kic_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] key
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // [7:0] echo_char, [39:8] result_value
   output logic [2:0]       rsp_tuser   // [0] echo_valid, [1] result_valid,
                                        // [2] was_division
);

   ctl_state_type     state_ff, state_in;
   logic              phase_ff, phase_in;
   logic [DATA_W-1:0] first_ff, first_in;
   logic [DATA_W-1:0] second_ff, second_in;
   calc_op_type       opcode_ff, opcode_in;
   logic              job_eq_ff, job_eq_in;
   logic [KEY_W-1:0]  key_ff, key_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              o_echo_ff, o_echo_in;
   logic [KEY_W-1:0]  o_char_ff, o_char_in;
   logic              o_res_ff, o_res_in;
   logic [DATA_W-1:0] o_value_ff, o_value_in;
   logic              o_div_ff, o_div_in;

   logic              accept;
   logic [KEY_W-1:0]  key;
   op_lookup_type     op_hit;
   eng_cmd_type       eng_cmd;
   eng_stat_type      eng_stat;
   logic [DATA_W-1:0] eng_a, eng_b, eng_result;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign key        = req_tdata;
   assign op_hit     = op_lookup(key);

   kic_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cmd    (eng_cmd),
      .opa    (eng_a),
      .opb    (eng_b),
      .stat   (eng_stat),
      .result (eng_result)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= 1'b0;
         first_ff     <= '0;
         second_ff    <= '0;
         opcode_ff    <= OP_ADD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         opcode_ff    <= opcode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      job_eq_ff  <= job_eq_in;
      key_ff     <= key_in;
      o_echo_ff  <= o_echo_in;
      o_char_ff  <= o_char_in;
      o_res_ff   <= o_res_in;
      o_value_ff <= o_value_in;
      o_div_ff   <= o_div_in;
   end

   // decode keys, drive the engine, load the output beat
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      opcode_in    = opcode_ff;
      job_eq_in    = job_eq_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      o_echo_in    = o_echo_ff;
      o_char_in    = o_char_ff;
      o_res_in     = o_res_ff;
      o_value_in   = o_value_ff;
      o_div_in     = o_div_ff;
      eng_cmd      = '0;
      eng_a        = first_ff;
      eng_b        = TEN;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in     = key;
               // default: key dropped, answer with an empty beat
               rsp_valid_in = 1'b1;
               o_echo_in    = 1'b0;
               o_char_in    = '0;
               o_res_in     = 1'b0;
               o_value_in   = '0;
               o_div_in     = 1'b0;
               if (is_digit(key)) begin
                  rsp_valid_in  = 1'b0;
                  job_eq_in     = 1'b0;
                  eng_cmd.start = 1'b1;
                  eng_cmd.op    = ENG_ACC;
                  eng_cmd.digit = key[DIG_W-1:0];
                  eng_a         = phase_ff ? second_ff : first_ff;
                  eng_b         = TEN;
                  state_in      = S_BUSY;
               end else if (!phase_ff) begin
                  if (is_positive(first_ff) && op_hit.hit) begin
                     opcode_in = op_hit.code;
                     phase_in  = 1'b1;
                     o_echo_in = 1'b1;
                     o_char_in = key;
                  end
               end else if ((key == KEY_EQUALS) && is_positive(second_ff)) begin
                  rsp_valid_in  = 1'b0;
                  job_eq_in     = 1'b1;
                  eng_cmd.start = 1'b1;
                  eng_cmd.op    = calc_to_eng(opcode_ff);
                  eng_a         = first_ff;
                  eng_b         = second_ff;
                  state_in      = S_BUSY;
               end
            end
         end
         S_BUSY: begin
            if (eng_stat.done) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            // output register is empty here; write back and emit
            rsp_valid_in = 1'b1;
            o_echo_in    = 1'b1;
            o_char_in    = key_ff;
            o_res_in     = job_eq_ff;
            o_value_in   = job_eq_ff ? eng_result : '0;
            o_div_in     = job_eq_ff && (opcode_ff == OP_DIV);
            if (job_eq_ff) begin
               phase_in  = 1'b0;
               first_in  = '0;
               second_in = '0;
               opcode_in = OP_ADD;
            end else if (phase_ff) begin
               second_in = eng_result;
            end else begin
               first_in = eng_result;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {o_value_ff, o_char_ff};
   assign rsp_tuser  = {o_div_ff, o_res_ff, o_echo_ff};

   // the engine starts only with an empty output register
   assert property (@(posedge clock) disable iff (reset)
      eng_cmd.start |-> !rsp_valid_ff)
      else $error("engine started while a result beat waits");

   // a finished engine job is written back in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (eng_stat.done && (state_ff == S_BUSY)) |=> (state_ff == S_LOAD))
      else $error("engine result not taken after finish");

   // a result beat always carries the echoed equals key
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tuser[0] && (rsp_tdata[7:0] == KEY_EQUALS)))
      else $error("result without echoed equals key");

   // division flag only rides on a result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> rsp_tuser[1])
      else $error("division flag without result");

endmodule
`default_nettype wire
